// File: hw/rtl/bu2x_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upsampler package
// Shared widths, register indexes and the record types passed between the
// front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package bu2x_pkg;

  localparam int MAX_WIDTH      = 1024;
  localparam int MAX_ROWS       = 4096;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int ROW_BITS       = $clog2(MAX_ROWS);
  localparam int SAMPLE_BITS    = 24;
  localparam int VALUE_BITS     = SAMPLE_BITS + 2;
  localparam int SW_BITS        = 11;
  localparam int SH_BITS        = 13;
  localparam int OX_BITS        = 11;
  localparam int OY_BITS        = 13;
  localparam int CFG_ADDR_BITS  = 3;
  localparam int CFG_DATA_BITS  = 13;
  localparam int IN_TDATA_BITS  = 24;
  localparam int OUT_TDATA_BITS = 104;
  localparam int NUM_SUB        = 4;
  localparam int SUB_BITS       = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS      = QPTR_BITS + 1;

  localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WIN_COL    = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_WIN_ROW    = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OUT_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_OUT_HEIGHT = 3'd5;

  localparam logic [SUB_BITS-1:0] SUB_DIAG  = 2'd0;
  localparam logic [SUB_BITS-1:0] SUB_ABOVE = 2'd1;
  localparam logic [SUB_BITS-1:0] SUB_LEFT  = 2'd2;
  localparam logic [SUB_BITS-1:0] SUB_SELF  = 2'd3;

  localparam logic [VALUE_BITS-1:0] VALUE_TOP    = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VALUE_BOTTOM = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [SW_BITS-1:0]  src_width;
    logic [SH_BITS-1:0]  src_height;
    logic [COL_BITS-1:0] win_col;
    logic [ROW_BITS-1:0] win_row;
    logic [OX_BITS-1:0]  out_width;
    logic [OY_BITS-1:0]  out_height;
  } cfg_t;

  typedef struct packed {
    logic                                 tile_start;
    logic [NUM_SUB-1:0]                   emit;
    logic [NUM_SUB-1:0]                   last;
    logic [OX_BITS-1:0]                   ox;
    logic [OY_BITS-1:0]                   oy;
    logic [NUM_SUB-1:0][VALUE_BITS-1:0]   value;
  } job_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [OX_BITS-1:0]    col;
    logic [OY_BITS-1:0]    row;
    logic                  last;
    logic [VALUE_BITS-1:0] run_min;
    logic [VALUE_BITS-1:0] run_max;
  } result_t;

endpackage

// File: hw/rtl/bu2x_front.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upsampler front end
// Tracks the source position, keeps the previous row in a line memory and
// turns each sample into a job of up to four interpolated points.
// ----------------------------------------------------------------------------
module bu2x_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bu2x_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bu2x_pkg::SAMPLE_BITS-1:0]  in_sample,
  output logic                              job_valid,
  input  logic                              job_ready,
  output bu2x_pkg::job_t                    job
);
  import bu2x_pkg::*;

  logic [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
  logic [SAMPLE_BITS-1:0] rd_r;

  logic [COL_BITS-1:0]    col_r, col_nxt;
  logic [ROW_BITS-1:0]    row_r, row_nxt;
  logic [SAMPLE_BITS-1:0] left_r;
  logic [SAMPLE_BITS-1:0] above_left_r;

  logic                   st_valid_r;
  logic [SAMPLE_BITS-1:0] st_sample_r;
  logic [SAMPLE_BITS-1:0] st_left_r;
  logic [OX_BITS-1:0]     st_ox_r;
  logic [OY_BITS-1:0]     st_oy_r;
  logic                   st_in_win_r;
  logic                   st_tile_r;

  logic [SW_BITS-1:0]  eff_w;
  logic [SH_BITS-1:0]  eff_h;
  logic [COL_BITS-1:0] c_eff;
  logic [ROW_BITS-1:0] r_eff;
  logic [SW_BITS-1:0]  c_inc;
  logic [SH_BITS-1:0]  r_inc;
  logic                in_win;
  logic [COL_BITS-1:0] dx;
  logic [ROW_BITS-1:0] dy;
  logic                accept;
  logic                advance;

  logic signed [VALUE_BITS-1:0] s_x, above_x, left_x, diag_x, above_sum, left_sum;
  logic                         has_x, has_y, xo_ok, xe_ok, yo_ok, ye_ok;
  logic                         xo_last, xe_last, yo_last, ye_last;
  logic [OX_BITS:0]             ox_inc;
  logic [OY_BITS:0]             oy_inc;

  always_comb begin
    eff_w = cfg.src_width;
    if (eff_w == '0) begin
      eff_w = SW_BITS'(1);
    end else if (eff_w > SW_BITS'(MAX_WIDTH)) begin
      eff_w = SW_BITS'(MAX_WIDTH);
    end
    eff_h = cfg.src_height;
    if (eff_h == '0) begin
      eff_h = SH_BITS'(1);
    end else if (eff_h > SH_BITS'(MAX_ROWS)) begin
      eff_h = SH_BITS'(MAX_ROWS);
    end
    c_eff = (SW_BITS'(col_r) >= eff_w) ? '0 : col_r;
    r_eff = (SH_BITS'(row_r) >= eff_h) ? '0 : row_r;
    c_inc = SW_BITS'(c_eff) + SW_BITS'(1);
    r_inc = SH_BITS'(r_eff) + SH_BITS'(1);
    if (c_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= eff_h) ? '0 : r_inc[ROW_BITS-1:0];
    end else begin
      col_nxt = c_inc[COL_BITS-1:0];
      row_nxt = r_eff;
    end
    in_win = (r_eff >= cfg.win_row) && (c_eff >= cfg.win_col);
    dx     = c_eff - cfg.win_col;
    dy     = r_eff - cfg.win_row;
  end

  assign advance  = st_valid_r && job_ready;
  assign in_ready = !st_valid_r || job_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r           <= line_mem[c_eff];
      line_mem[c_eff] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      left_r       <= '0;
      above_left_r <= '0;
      st_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= in_sample;
      end
      if (advance) begin
        above_left_r <= rd_r;
      end
      if (accept) begin
        st_valid_r <= 1'b1;
      end else if (advance) begin
        st_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_sample_r <= in_sample;
      st_left_r   <= left_r;
      st_ox_r     <= {dx, 1'b0};
      st_oy_r     <= {dy, 1'b0};
      st_in_win_r <= in_win;
      st_tile_r   <= (r_eff == '0) && (c_eff == '0);
    end
  end

  always_comb begin
    s_x       = {{(VALUE_BITS-SAMPLE_BITS){st_sample_r[SAMPLE_BITS-1]}}, st_sample_r};
    above_x   = {{(VALUE_BITS-SAMPLE_BITS){rd_r[SAMPLE_BITS-1]}}, rd_r};
    left_x    = {{(VALUE_BITS-SAMPLE_BITS){st_left_r[SAMPLE_BITS-1]}}, st_left_r};
    diag_x    = {{(VALUE_BITS-SAMPLE_BITS){above_left_r[SAMPLE_BITS-1]}}, above_left_r};
    above_sum = above_x + s_x;
    left_sum  = left_x + s_x;

    has_x   = st_ox_r != '0;
    has_y   = st_oy_r != '0;
    xo_ok   = st_ox_r <= cfg.out_width;
    xe_ok   = st_ox_r < cfg.out_width;
    yo_ok   = st_oy_r <= cfg.out_height;
    ye_ok   = st_oy_r < cfg.out_height;
    ox_inc  = (OX_BITS+1)'(st_ox_r) + (OX_BITS+1)'(1);
    oy_inc  = (OY_BITS+1)'(st_oy_r) + (OY_BITS+1)'(1);
    xo_last = st_ox_r == cfg.out_width;
    xe_last = ox_inc == (OX_BITS+1)'(cfg.out_width);
    yo_last = st_oy_r == cfg.out_height;
    ye_last = oy_inc == (OY_BITS+1)'(cfg.out_height);

    job.tile_start       = st_tile_r;
    job.ox               = st_ox_r;
    job.oy               = st_oy_r;
    job.value[SUB_DIAG]  = diag_x + above_x + left_x + s_x;
    job.value[SUB_ABOVE] = {above_sum[VALUE_BITS-2:0], 1'b0};
    job.value[SUB_LEFT]  = {left_sum[VALUE_BITS-2:0], 1'b0};
    job.value[SUB_SELF]  = {s_x[VALUE_BITS-3:0], 2'b00};
    job.emit[SUB_DIAG]   = st_in_win_r && has_x && has_y && xo_ok && yo_ok;
    job.emit[SUB_ABOVE]  = st_in_win_r && has_y && xe_ok && yo_ok;
    job.emit[SUB_LEFT]   = st_in_win_r && has_x && xo_ok && ye_ok;
    job.emit[SUB_SELF]   = st_in_win_r && xe_ok && ye_ok;
    job.last[SUB_DIAG]   = xo_last && yo_last;
    job.last[SUB_ABOVE]  = xe_last && yo_last;
    job.last[SUB_LEFT]   = xo_last && ye_last;
    job.last[SUB_SELF]   = xe_last && ye_last;
  end

  assign job_valid = st_valid_r;

endmodule

// File: hw/rtl/bu2x_queue.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upsampler job queue
// Small first-in first-out buffer of jobs between the front and back ends.
// ----------------------------------------------------------------------------
module bu2x_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  bu2x_pkg::job_t  push_job,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bu2x_pkg::job_t  pop_job
);
  import bu2x_pkg::*;

  job_t                 store_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] count_r;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = count_r != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_BITS'(1);
      end
    end
  end

endmodule

// File: hw/rtl/bu2x_back.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upsampler back end
// Emits the points of each job one per cycle while the output can take them,
// tracks the running extremes and holds the result in an output register.
// ----------------------------------------------------------------------------
module bu2x_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  bu2x_pkg::job_t     job,
  output logic               out_valid,
  input  logic               out_ready,
  output bu2x_pkg::result_t  result
);
  import bu2x_pkg::*;

  job_t                  wk_r;
  logic                  wk_valid_r;
  logic                  out_valid_r;
  result_t               res_r;
  logic [VALUE_BITS-1:0] min_r;
  logic [VALUE_BITS-1:0] max_r;

  logic [SUB_BITS-1:0]   sel;
  logic [NUM_SUB-1:0]    sel_oh;
  logic [NUM_SUB-1:0]    mask_left;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] min_new;
  logic [VALUE_BITS-1:0] max_new;
  logic                  can_load;
  logic                  emit_go;
  logic                  wk_done;

  always_comb begin
    if (wk_r.emit[SUB_DIAG]) begin
      sel = SUB_DIAG;
    end else if (wk_r.emit[SUB_ABOVE]) begin
      sel = SUB_ABOVE;
    end else if (wk_r.emit[SUB_LEFT]) begin
      sel = SUB_LEFT;
    end else begin
      sel = SUB_SELF;
    end
    sel_oh    = NUM_SUB'(1) << sel;
    mask_left = wk_r.emit & ~sel_oh;
    val       = wk_r.value[sel];
    min_new   = ($signed(val) < $signed(min_r)) ? val : min_r;
    max_new   = ($signed(val) > $signed(max_r)) ? val : max_r;
    can_load  = !out_valid_r || out_ready;
    emit_go   = wk_valid_r && (wk_r.emit != '0) && can_load;
    wk_done   = !wk_valid_r || (wk_r.emit == '0) || (emit_go && (mask_left == '0));
  end

  assign job_ready = wk_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      wk_valid_r  <= 1'b0;
      min_r       <= VALUE_TOP;
      max_r       <= VALUE_BOTTOM;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (wk_done) begin
        wk_valid_r <= job_valid;
      end
      if (wk_done && job_valid) begin
        wk_r <= job;
      end else if (emit_go) begin
        wk_r.emit <= mask_left;
      end
      if (wk_done && job_valid && job.tile_start) begin
        min_r <= VALUE_TOP;
        max_r <= VALUE_BOTTOM;
      end else if (emit_go) begin
        min_r <= min_new;
        max_r <= max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      res_r.value   <= val;
      res_r.col     <= (sel == SUB_DIAG || sel == SUB_LEFT) ?
                       wk_r.ox - OX_BITS'(1) : wk_r.ox;
      res_r.row     <= (sel == SUB_DIAG || sel == SUB_ABOVE) ?
                       wk_r.oy - OY_BITS'(1) : wk_r.oy;
      res_r.last    <= wk_r.last[sel];
      res_r.run_min <= min_new;
      res_r.run_max <= max_new;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

// File: hw/rtl/bilinear_upsample_2x.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upsampler
// Streams source elevation samples in raster order and emits the 2x
// bilinear grid of a configured window with coordinates and running extremes.
// ----------------------------------------------------------------------------
// Usage: samples enter on the in_ channel, one per transfer, in raster order
// over a src_width x src_height tile. Every transfer yields zero to four
// results on the out_ channel, each with its grid column and row, a last flag
// for the bottom-right point of the window and the tile's running minimum and
// maximum. Registers are written through cfg_ while the block is idle.
// A sample passes the front-end stage register, the job queue and the back
// end's work register before its first result reaches the output register.
// The back end has one output register and sends one result per cycle
// while the receiver takes them; a sample with no results still passes through.
// The front end takes a new sample every cycle while its job queue has room.
// A stalled receiver holds the output register, fills the queue and then
// deasserts in_tready. Reset clears the position counters, neighbor samples,
// queue and extremes; the line memory is not cleared, and the first source
// row of each tile refills it before it is read.
// ----------------------------------------------------------------------------
module bilinear_upsample_2x (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bu2x_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [bu2x_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // sample [23:0]
  input  logic [bu2x_pkg::IN_TDATA_BITS-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // value [25:0], out_col [36:26], out_row [49:37], run_min [75:50],
  // run_max [101:76], zero [103:102]
  output logic [bu2x_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  output logic                                 out_tlast
);
  import bu2x_pkg::*;

  cfg_t    cfg_r;
  logic    job_valid;
  logic    job_ready;
  job_t    job_in;
  logic    q_valid;
  logic    q_ready;
  job_t    q_job;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width  <= SW_BITS'(257);
      cfg_r.src_height <= SH_BITS'(257);
      cfg_r.win_col    <= '0;
      cfg_r.win_row    <= '0;
      cfg_r.out_width  <= OX_BITS'(513);
      cfg_r.out_height <= OY_BITS'(513);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SRC_WIDTH:  cfg_r.src_width  <= cfg_wdata[SW_BITS-1:0];
        REG_SRC_HEIGHT: cfg_r.src_height <= cfg_wdata[SH_BITS-1:0];
        REG_WIN_COL:    cfg_r.win_col    <= cfg_wdata[COL_BITS-1:0];
        REG_WIN_ROW:    cfg_r.win_row    <= cfg_wdata[ROW_BITS-1:0];
        REG_OUT_WIDTH:  cfg_r.out_width  <= cfg_wdata[OX_BITS-1:0];
        REG_OUT_HEIGHT: cfg_r.out_height <= cfg_wdata[OY_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  bu2x_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job_in)
  );

  bu2x_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_job   (job_in),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  bu2x_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (res)
  );

  assign out_tdata = {2'b00, res.run_max, res.run_min, res.row, res.col, res.value};
  assign out_tlast = res.last;

  a_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.col < cfg_r.out_width) && (res.row < cfg_r.out_height))
    else $error("result outside the output grid");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      ((12'(res.col) + 12'd1) == 12'(cfg_r.out_width)) &&
      ((14'(res.row) + 14'd1) == 14'(cfg_r.out_height)))
    else $error("last flag away from the bottom-right corner");

  a_extremes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(res.run_min) <= $signed(res.value)) &&
                   ($signed(res.value) <= $signed(res.run_max)))
    else $error("value outside its running extremes");

endmodule

// File: tb/bilinear_upsample_2x_test.sv
// ----------------------------------------------------------------------------
// Bilinear 2x upsampler testbench
// Drives source tiles into the upsampler under a series of register settings.
// A short directed table opens the run: extreme samples in small full-upscale
// tiles. Random phases follow. They cover clamped registers and the off-tile
// and right-edge windows. Every result transfer is checked
// field by field against an in-order queue. An internal model of the line
// buffer and the running extremes fills that queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bilinear_upsample_2x_test;
  import bu2x_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PROBE_COUNT  = 20;
  localparam int RANDOM_ITEMS = 280;

  typedef struct {
    int unsigned src_width;
    int unsigned src_height;
    int unsigned win_col;
    int unsigned win_row;
    int unsigned out_width;
    int unsigned out_height;
  } tile_cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   typed;
    logic [VALUE_BITS-1:0]  value;
  } probe_row_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_TDATA_BITS-1:0]  in_tdata = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [OUT_TDATA_BITS-1:0] out_tdata;
  logic                      out_tlast;

  bilinear_upsample_2x u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Predicted grid points, oldest first.
  result_t points_due [$];
  int unsigned fault_count = 0;
  int tx_mode = 1;
  int rx_mode = 1;

  // Upsampler model state.
  tile_cfg_t grid_cfg = '{257, 257, 0, 0, 513, 513};
  logic signed [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] left_sample = '0;
  logic signed [SAMPLE_BITS-1:0] diag_sample = '0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic signed [VALUE_BITS-1:0] run_lo = VALUE_TOP;
  logic signed [VALUE_BITS-1:0] run_hi = VALUE_BOTTOM;

  // Tiles are 2x2 with a full 3x3 output grid. Typed rows open a tile.
  probe_row_t probe_rows [PROBE_COUNT] = '{
    '{24'h7FFFFF, 1'b1, 26'h1FFFFFC}, '{24'h7FFFFF, 1'b0, '0},
    '{24'h7FFFFF, 1'b0, '0},          '{24'h7FFFFF, 1'b0, '0},
    '{24'h800000, 1'b1, 26'h2000000}, '{24'h800000, 1'b0, '0},
    '{24'h800000, 1'b0, '0},          '{24'h800000, 1'b0, '0},
    '{24'h7FFFFF, 1'b1, 26'h1FFFFFC}, '{24'h800000, 1'b0, '0},
    '{24'h800000, 1'b0, '0},          '{24'h7FFFFF, 1'b0, '0},
    '{24'h000000, 1'b1, 26'h0000000}, '{24'hFFFFFF, 1'b0, '0},
    '{24'h000001, 1'b0, '0},          '{24'h800000, 1'b0, '0},
    '{24'hAAAAAA, 1'b0, '0},          '{24'h555555, 1'b0, '0},
    '{24'h555555, 1'b0, '0},          '{24'hAAAAAA, 1'b0, '0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clamp_width(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned clamp_height(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_ROWS) return MAX_ROWS;
    return v;
  endfunction

  function automatic void emit_point(logic signed [VALUE_BITS-1:0] v,
                                     int unsigned ox, int unsigned oy);
    result_t p;
    if (ox >= grid_cfg.out_width || oy >= grid_cfg.out_height) return;
    if (v < run_lo) run_lo = v;
    if (v > run_hi) run_hi = v;
    p.value   = v;
    p.col     = ox[OX_BITS-1:0];
    p.row     = oy[OY_BITS-1:0];
    p.last    = (ox + 1 == grid_cfg.out_width) && (oy + 1 == grid_cfg.out_height);
    p.run_min = run_lo;
    p.run_max = run_hi;
    points_due.push_back(p);
  endfunction

  function automatic void interpolate_sample(logic signed [SAMPLE_BITS-1:0] s);
    int unsigned ew, eh, c, r, ox, oy;
    logic signed [SAMPLE_BITS-1:0] up;
    logic signed [VALUE_BITS-1:0] s_x, up_x, dg_x, lf_x;
    ew = clamp_width(grid_cfg.src_width);
    eh = clamp_height(grid_cfg.src_height);
    c = (col_pos >= ew) ? 0 : col_pos;
    r = (row_pos >= eh) ? 0 : row_pos;
    if (r == 0 && c == 0) begin
      run_lo = VALUE_TOP;
      run_hi = VALUE_BOTTOM;
    end
    up   = line_mem[c[COL_BITS-1:0]];
    s_x  = VALUE_BITS'(s);
    up_x = VALUE_BITS'(up);
    dg_x = VALUE_BITS'(diag_sample);
    lf_x = VALUE_BITS'(left_sample);
    if (r >= grid_cfg.win_row && c >= grid_cfg.win_col) begin
      ox = 2 * (c - grid_cfg.win_col);
      oy = 2 * (r - grid_cfg.win_row);
      if (oy >= 1 && ox >= 1) emit_point(dg_x + up_x + lf_x + s_x, ox - 1, oy - 1);
      if (oy >= 1) emit_point(VALUE_BITS'(2 * (up_x + s_x)), ox, oy - 1);
      if (ox >= 1) emit_point(VALUE_BITS'(2 * (lf_x + s_x)), ox - 1, oy);
      emit_point(VALUE_BITS'(4 * s_x), ox, oy);
    end
    line_mem[c[COL_BITS-1:0]] = s;
    diag_sample = up;
    left_sample = s;
    c++;
    if (c >= ew) begin
      c = 0;
      r++;
      if (r >= eh) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 17);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'hFFFFFF;
      3: return 24'($urandom_range(0, 255));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic tile_cfg_t random_cfg();
    tile_cfg_t c;
    int unsigned span_x, span_y;
    c.src_width  = $urandom_range(2, 9);
    c.src_height = $urandom_range(2, 6);
    c.win_col = ($urandom_range(0, 5) == 0) ? $urandom_range(0, c.src_width + 2)
                                           : $urandom_range(0, c.src_width - 1);
    c.win_row = ($urandom_range(0, 5) == 0) ? $urandom_range(0, c.src_height + 2)
                                           : $urandom_range(0, c.src_height - 1);
    span_x = (c.src_width > c.win_col) ? 2 * (c.src_width - c.win_col) - 1 : 1;
    span_y = (c.src_height > c.win_row) ? 2 * (c.src_height - c.win_row) - 1 : 1;
    c.out_width  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, span_x + 2) : span_x;
    c.out_height = ($urandom_range(0, 2) == 0) ? $urandom_range(0, span_y + 2) : span_y;
    return c;
  endfunction

  // The first phases pin the register extremes; the rest are random.
  function automatic tile_cfg_t pick_config(int unsigned phase_idx);
    tile_cfg_t c;
    case (phase_idx)
      0: c = '{2, 2, 0, 0, 1, 1};
      1: begin
        c = random_cfg();
        c.out_width = 0;
      end
      2: c = '{0, 3, 0, 0, 2047, 8191};
      3: c = '{5, 0, 2, 0, 2047, 8191};
      4: c = '{4, 3, 1023, 4095, 1, 1};
      default: c = random_cfg();
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_BITS'(val);
    @(posedge clk);
  endtask

  task automatic apply_config(input tile_cfg_t c);
    write_reg(REG_SRC_WIDTH,  c.src_width);
    write_reg(REG_SRC_HEIGHT, c.src_height);
    write_reg(REG_WIN_COL,    c.win_col);
    write_reg(REG_WIN_ROW,    c.win_row);
    write_reg(REG_OUT_WIDTH,  c.out_width);
    write_reg(REG_OUT_HEIGHT, c.out_height);
    cfg_we <= 1'b0;
    grid_cfg = c;
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_until_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (points_due.size() != 0);
  endtask

  // Items that yield no point may still sit in the block's queue.
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_field(input string name, input logic [VALUE_BITS-1:0] want,
                              input logic [VALUE_BITS-1:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 40)
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic check_point(input result_t got);
    result_t want;
    if (points_due.size() == 0) begin
      fault_count++;
      if (fault_count <= 40)
        $display("%0t: unexpected transfer, expected none, got value %h col %0d row %0d",
                 $time, got.value, got.col, got.row);
      return;
    end
    want = points_due.pop_front();
    report_field("value",   want.value,   got.value);
    report_field("out_col", VALUE_BITS'(want.col),  VALUE_BITS'(got.col));
    report_field("out_row", VALUE_BITS'(want.row),  VALUE_BITS'(got.row));
    report_field("last",    VALUE_BITS'(want.last), VALUE_BITS'(got.last));
    report_field("run_min", want.run_min, got.run_min);
    report_field("run_max", want.run_max, got.run_max);
  endtask

  initial begin : result_sink
    result_t got;
    int gap;
    int unsigned taken;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 50 == 0) rx_mode = $urandom_range(0, 2);
      gap = draw_gap(rx_mode);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      got.value   = out_tdata[25:0];
      got.col     = out_tdata[36:26];
      got.row     = out_tdata[49:37];
      got.last    = out_tlast;
      got.run_min = out_tdata[75:50];
      got.run_max = out_tdata[101:76];
      check_point(got);
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    tile_cfg_t c;
    int unsigned n, tiles, phase_idx, random_items, queued;
    logic [SAMPLE_BITS-1:0] s;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    apply_config('{2, 2, 0, 0, 3, 3});
    for (int i = 0; i < PROBE_COUNT; i++) begin
      if (i == 12) hold_until_drained();
      send_sample(probe_rows[i].sample);
      queued = points_due.size();
      interpolate_sample(probe_rows[i].sample);
      if (probe_rows[i].typed) begin
        while (points_due.size() > queued) void'(points_due.pop_back());
        points_due.push_back('{value: probe_rows[i].value, col: '0, row: '0, last: 1'b0,
                               run_min: probe_rows[i].value, run_max: probe_rows[i].value});
      end
    end

    phase_idx = 0;
    random_items = 0;
    while (phase_idx < 5 || random_items < RANDOM_ITEMS) begin
      c = pick_config(phase_idx);
      tiles = $urandom_range(1, 3);
      settle();
      apply_config(c);
      tx_mode = $urandom_range(0, 2);
      n = clamp_width(c.src_width) * clamp_height(c.src_height) * tiles;
      for (int unsigned k = 0; k < n; k++) begin
        if (k == n / 2 && $urandom_range(0, 3) == 0) hold_until_drained();
        s = draw_sample();
        send_sample(s);
        interpolate_sample(s);
      end
      random_items += n;
      phase_idx++;
    end

    settle();
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/bu2x_pkg.sv
hw/rtl/bu2x_front.sv
hw/rtl/bu2x_queue.sv
hw/rtl/bu2x_back.sv
hw/rtl/bilinear_upsample_2x.sv
tb/bilinear_upsample_2x_test.sv
